// ===== sv/wlhu_pkg.sv =====
package wlhu_pkg;

   // Fixed field widths
   localparam int BIN_W     = 8;
   localparam int BINS_W    = 9;
   localparam int FLAT_W    = 11;
   localparam int FACTOR_W  = 48;
   localparam int VISITS_W  = 32;
   localparam int TOTAL_W   = 40;
   localparam int DENSITY_W = 64;

   // Fixed point of the modification factor
   localparam int FRAC_BITS = 40;

   // Halving floor: 1e-9 rounded to nearest at FRAC_BITS fraction bits
   localparam logic [63:0] FLOOR_VALUE =
      ((64'd1 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;

   // Total of a walk saturates here
   localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

   // Counts enter the flatness product clamped to this value
   localparam int          CLAMP_W     = TOTAL_W + 2;
   localparam logic [63:0] COUNT_CLAMP = 64'd1 << (TOTAL_W + 1);

   // Shared multiplier: CLAMP_W x FLAT_W
   localparam int MUL_W = CLAMP_W + FLAT_W;

   // Configuration reset values
   localparam logic [BINS_W-1:0]   BINS_RST   = 9'd256;
   localparam logic [FLAT_W-1:0]   FLAT_RST   = 11'd819;
   localparam logic [FACTOR_W-1:0] FACTOR_RST = 48'd1099511627776;
   localparam logic [FACTOR_W-1:0] STOP_RST   = 48'd10995;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BINS_IN_USE    = 2'd0,
      CSR_FLATNESS       = 2'd1,
      CSR_FACTOR_START   = 2'd2,
      CSR_STOP_THRESHOLD = 2'd3
   } csr_index_type;

   // Commands from the sequencer to the walk datapath
   typedef struct packed {
      logic start;    // open a walk: zero the total, preset the minimum
      logic acc;      // fold one count into total and minimum
      logic mul_thr;  // flatness * total into the threshold register
      logic mul_min;  // clamped minimum * bin count into the product register
   } walk_ctl_type;

endpackage

// ===== sv/wlhu_if.sv =====
interface wlhu_req_if;
   logic                      valid;
   logic                      ready;
   logic [wlhu_pkg::BIN_W-1:0] bin;

   modport source (output valid, output bin, input ready);
   modport sink   (input valid, input bin, output ready);
endinterface

interface wlhu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wlhu_pkg::FACTOR_W-1:0] factor;
   logic [wlhu_pkg::VISITS_W-1:0] bin_visits;
   logic                         flat_reached;
   logic                         hist_cleared;
   logic                         converged;
   logic                         bin_error;

   modport source (output valid, output factor, output bin_visits, output flat_reached,
                   output hist_cleared, output converged, output bin_error, input ready);
   modport sink   (input valid, input factor, input bin_visits, input flat_reached,
                   input hist_cleared, input converged, input bin_error, output ready);
endinterface

// ===== sv/wlhu_walk.sv =====
module wlhu_walk #(
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  wlhu_pkg::walk_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]         count,
   input  logic [wlhu_pkg::BINS_W-1:0]   nb,
   input  logic [wlhu_pkg::FLAT_W-1:0]   flatness,
   output logic                          flat
);
   import wlhu_pkg::*;

   logic [TOTAL_W-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0] min_ff, min_in;
   logic [MUL_W-1:0]      thr_ff, thr_in;
   logic [MUL_W-1:0]      prod_ff, prod_in;
   logic [63:0]           sum_wide;
   logic [63:0]           min_wide;
   logic [CLAMP_W-1:0]    min_clamped;
   logic [CLAMP_W-1:0]    mul_a;
   logic [FLAT_W-1:0]     mul_b;
   logic [MUL_W-1:0]      product;

   // Saturating total and running minimum over the walked counts
   always_comb begin
      sum_wide = 64'(sum_ff) + 64'(count);
      min_wide = 64'(min_ff);
      sum_in   = sum_ff;
      min_in   = min_ff;
      if (ctl.start) begin
         sum_in = '0;
         min_in = '1;
      end else if (ctl.acc) begin
         sum_in = (sum_wide > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum_wide[TOTAL_W-1:0];
         if (count < min_ff) begin
            min_in = count;
         end
      end
   end

   // Clamp the minimum before it enters the product
   assign min_clamped = (min_wide > COUNT_CLAMP) ? COUNT_CLAMP[CLAMP_W-1:0]
                                                 : min_wide[CLAMP_W-1:0];

   // One shared multiplier: threshold first, then the minimum bin's side
   assign mul_a   = ctl.mul_thr ? CLAMP_W'(sum_ff) : min_clamped;
   assign mul_b   = ctl.mul_thr ? flatness : FLAT_W'(nb);
   assign product = MUL_W'(mul_a * mul_b);

   assign thr_in  = ctl.mul_thr ? product : thr_ff;
   assign prod_in = ctl.mul_min ? product : prod_ff;

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      min_ff  <= min_in;
      thr_ff  <= thr_in;
      prod_ff <= prod_in;
   end

   // Flat when the smallest count passes, since every bin shares the threshold
   assign flat = {prod_ff, 10'b0} >= {10'b0, thr_ff};

endmodule

// ===== sv/wang_landau_histogram_update.sv =====
// Wang-Landau flat-histogram update. Each request beat carries the energy bin
// of a visited state; each one yields exactly one response beat. A bin in use
// gets its visit count incremented (saturating) and the current modification
// factor added to its log density (saturating). The block then walks the
// visit counts of all bins in use through one memory read port, one bin per
// cycle, keeping the total and the minimum; one shared multiplier then forms
// both sides of the flatness test. A flat histogram that clears the counts
// adds a sweep over all NUM_BINS entries before its response, and a bin out
// of use skips the update and the walk. After reset the block sweeps all
// NUM_BINS entries of both memories before it accepts a request;
// configuration writes are taken at any time, but should only be issued
// while no request is in flight. Writing factor_start also loads the
// current factor. The response register lets the next request be taken
// while the previous response still waits.
module wang_landau_histogram_update #(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   wlhu_req_if.sink                      req_chan,
   wlhu_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  wlhu_pkg::csr_index_type       csr_index,
   input  logic [wlhu_pkg::FACTOR_W-1:0] csr_wdata
);
   import wlhu_pkg::*;

   localparam int AW     = $clog2(NUM_BINS);
   localparam int CW     = (AW > BINS_W) ? AW : BINS_W;
   localparam int NB_CAP = (NUM_BINS < 511) ? NUM_BINS : 511;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_UPD,
      S_SUM,
      S_DRAIN,
      S_THR,
      S_MIN,
      S_DECIDE,
      S_WIPE,
      S_DONE
   } state_type;

   // Bin stores
   logic [COUNT_BITS-1:0] count_mem [NUM_BINS];
   logic [DENSITY_W-1:0]  den_mem   [NUM_BINS];
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [DENSITY_W-1:0]  den_rd_ff;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  cnt_we;
   logic                  den_we;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [DENSITY_W-1:0]  den_wdata;

   // Sequencer and configuration
   state_type             state_ff, state_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  rd_v_ff, rd_v_in;
   logic [AW-1:0]         bin_ff, bin_in;
   logic [BINS_W-1:0]     bins_ff, bins_in;
   logic [FLAT_W-1:0]     flatness_ff, flatness_in;
   logic [FACTOR_W-1:0]   start_ff, start_in;
   logic [FACTOR_W-1:0]   stop_ff, stop_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [VISITS_W-1:0]   visits_ff, visits_in;
   logic                  flat_ff, flat_in;
   logic                  cleared_ff, cleared_in;
   logic                  err_ff, err_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0]   rsp_factor_ff, rsp_factor_in;
   logic [VISITS_W-1:0]   rsp_visits_ff, rsp_visits_in;
   logic                  rsp_flat_ff, rsp_flat_in;
   logic                  rsp_cleared_ff, rsp_cleared_in;
   logic                  rsp_conv_ff, rsp_conv_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic [BINS_W-1:0]     nb;
   logic                  walk_last;
   logic                  sweep_last;
   logic                  bin_bad;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [DENSITY_W:0]    den_sum;
   logic [FACTOR_W-1:0]   factor_half;
   logic                  walk_flat;
   walk_ctl_type          ctl;

   // Effective bin count: zero acts as one, clamp to the store depth
   always_comb begin
      if (bins_ff == '0) begin
         nb = BINS_W'(1);
      end else if (bins_ff > BINS_W'(NB_CAP)) begin
         nb = BINS_W'(NB_CAP);
      end else begin
         nb = bins_ff;
      end
   end

   assign bin_bad    = {1'b0, req_chan.bin} >= nb;
   assign walk_last  = CW'(idx_ff) == CW'(nb - BINS_W'(1));
   assign sweep_last = idx_ff == AW'(NUM_BINS - 1);

   // Saturating updates of the visited bin
   assign cnt_inc = (count_rd_ff == '1) ? count_rd_ff : count_rd_ff + COUNT_BITS'(1);
   assign den_sum = {1'b0, den_rd_ff} + (DENSITY_W + 1)'(factor_ff);

   assign factor_half = (factor_ff > FLOOR_VALUE[FACTOR_W-1:0]) ? (factor_ff >> 1) : factor_ff;

   wlhu_walk #(
      .COUNT_BITS (COUNT_BITS)
   ) u_walk (
      .clock    (clock),
      .ctl      (ctl),
      .count    (count_rd_ff),
      .nb       (nb),
      .flatness (flatness_ff),
      .flat     (walk_flat)
   );

   // Next state and datapath control
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_v_in        = 1'b0;
      bin_in         = bin_ff;
      bins_in        = bins_ff;
      flatness_in    = flatness_ff;
      start_in       = start_ff;
      stop_in        = stop_ff;
      factor_in      = factor_ff;
      visits_in      = visits_ff;
      flat_in        = flat_ff;
      cleared_in     = cleared_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_factor_in  = rsp_factor_ff;
      rsp_visits_in  = rsp_visits_ff;
      rsp_flat_in    = rsp_flat_ff;
      rsp_cleared_in = rsp_cleared_ff;
      rsp_conv_in    = rsp_conv_ff;
      rsp_err_in     = rsp_err_ff;
      rd_addr        = idx_ff;
      wr_addr        = idx_ff;
      cnt_we         = 1'b0;
      den_we         = 1'b0;
      cnt_wdata      = '0;
      den_wdata      = '0;
      req_chan.ready = 1'b0;
      ctl            = '0;
      ctl.acc        = rd_v_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_BINS_IN_USE:    bins_in = csr_wdata[BINS_W-1:0];
            CSR_FLATNESS:       flatness_in = csr_wdata[FLAT_W-1:0];
            CSR_FACTOR_START: begin
               start_in  = csr_wdata;
               factor_in = csr_wdata;
            end
            CSR_STOP_THRESHOLD: stop_in = csr_wdata;
         endcase
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // Zero both stores after reset
            cnt_we = 1'b1;
            den_we = 1'b1;
            if (sweep_last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            rd_addr        = AW'(req_chan.bin);
            if (req_chan.valid) begin
               bin_in     = AW'(req_chan.bin);
               flat_in    = 1'b0;
               cleared_in = 1'b0;
               if (bin_bad) begin
                  err_in    = 1'b1;
                  visits_in = '0;
                  state_in  = S_DONE;
               end else begin
                  err_in   = 1'b0;
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            // Write back the visited bin, open the walk
            wr_addr   = bin_ff;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_inc;
            den_we    = 1'b1;
            den_wdata = den_sum[DENSITY_W] ? '1 : den_sum[DENSITY_W-1:0];
            visits_in = VISITS_W'(cnt_inc);
            ctl.start = 1'b1;
            idx_in    = '0;
            state_in  = S_SUM;
         end
         S_SUM: begin
            // Read one bin per cycle
            rd_addr = idx_ff;
            rd_v_in = 1'b1;
            if (walk_last) begin
               idx_in   = '0;
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_THR;
         end
         S_THR: begin
            ctl.mul_thr = 1'b1;
            state_in    = S_MIN;
         end
         S_MIN: begin
            ctl.mul_min = 1'b1;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (walk_flat) begin
               flat_in   = 1'b1;
               factor_in = factor_half;
               if (factor_half >= stop_ff) begin
                  cleared_in = 1'b1;
                  idx_in     = '0;
                  state_in   = S_WIPE;
               end
            end
         end
         S_WIPE: begin
            // Clear every visit count
            cnt_we = 1'b1;
            if (sweep_last) begin
               idx_in   = '0;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_DONE: begin
            // Load the response once the register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_factor_in  = factor_ff;
               rsp_visits_in  = visits_ff;
               rsp_flat_in    = flat_ff;
               rsp_cleared_in = cleared_ff;
               rsp_conv_in    = factor_ff <= stop_ff;
               rsp_err_in     = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_v_ff      <= 1'b0;
         bins_ff      <= BINS_RST;
         flatness_ff  <= FLAT_RST;
         start_ff     <= FACTOR_RST;
         stop_ff      <= STOP_RST;
         factor_ff    <= FACTOR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_v_ff      <= rd_v_in;
         bins_ff      <= bins_in;
         flatness_ff  <= flatness_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         factor_ff    <= factor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff         <= bin_in;
      visits_ff      <= visits_in;
      flat_ff        <= flat_in;
      cleared_ff     <= cleared_in;
      err_ff         <= err_in;
      rsp_factor_ff  <= rsp_factor_in;
      rsp_visits_ff  <= rsp_visits_in;
      rsp_flat_ff    <= rsp_flat_in;
      rsp_cleared_ff <= rsp_cleared_in;
      rsp_conv_ff    <= rsp_conv_in;
      rsp_err_ff     <= rsp_err_in;
   end

   // Store ports: one write, one registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[wr_addr] <= cnt_wdata;
      end
      if (den_we) begin
         den_mem[wr_addr] <= den_wdata;
      end
      count_rd_ff <= count_mem[rd_addr];
      den_rd_ff   <= den_mem[rd_addr];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.factor       = rsp_factor_ff;
   assign rsp_chan.bin_visits   = rsp_visits_ff;
   assign rsp_chan.flat_reached = rsp_flat_ff;
   assign rsp_chan.hist_cleared = rsp_cleared_ff;
   assign rsp_chan.converged    = rsp_conv_ff;
   assign rsp_chan.bin_error    = rsp_err_ff;

endmodule
